/* rtl/dtlt_pkg.sv */
package dtlt_pkg;

  // matrix dimension the store sizes default to
  localparam int DimDefault = 16;

  // field widths
  localparam int IdxW  = 4;
  localparam int ValW  = 16;
  localparam int SizeW = 5;
  localparam int ProdW = 2 * ValW;
  localparam int SumW  = 35;
  // at most 31 terms are ever summed, so SizeW guard bits cover any sum
  localparam int AccW  = ProdW + SizeW;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(16);

  // item modes
  typedef enum logic [1:0] {
    MODE_LOAD_DENSE = 2'd0,
    MODE_LOAD_TRI   = 2'd1,
    MODE_QUERY      = 2'd2,
    MODE_NOP        = 2'd3
  } mode_e;

  typedef logic        [IdxW-1:0] idx_t;
  typedef logic signed [ValW-1:0] val_t;
  typedef logic signed [SumW-1:0] sum_t;

endpackage

/* rtl/dtlt_if.sv */
interface dtlt_in_if
  import dtlt_pkg::*;
;
  logic  valid;
  logic  ready;
  mode_e mode;
  idx_t  row_index;
  idx_t  col_index;
  val_t  element_value;

  modport source (output valid, mode, row_index, col_index, element_value, input ready);
  modport sink   (input valid, mode, row_index, col_index, element_value, output ready);
endinterface

interface dtlt_out_if
  import dtlt_pkg::*;
;
  logic valid;
  logic ready;
  sum_t product_value;
  idx_t out_row;
  idx_t out_col;
  logic out_of_range;

  modport source (output valid, product_value, out_row, out_col, out_of_range, input ready);
  modport sink   (input valid, product_value, out_row, out_col, out_of_range, output ready);
endinterface

/* rtl/dtlt_ram.sv */
module dtlt_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dtlt_mac.sv */
module dtlt_mac
  import dtlt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clr_i,
  input  logic vld_i,
  input  val_t a_i,
  input  val_t b_i,
  output logic busy_o,
  output sum_t sum_o
);

  localparam logic signed [AccW-1:0] SatHi = {{(AccW-SumW+1){1'b0}}, {(SumW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatLo = {{(AccW-SumW+1){1'b1}}, {(SumW-1){1'b0}}};

  logic signed [ProdW-1:0] prod_q;
  logic                    prod_vld_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [AccW-1:0]  sat;

  // multiply stage, registered before the add
  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      prod_q <= a_i * b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= vld_i;
      acc_q      <= acc_d;
    end
  end

  // accumulate stage
  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    end
  end

  // clamp to the result range
  always_comb begin
    sat = acc_q;
    if (acc_q > SatHi) begin
      sat = SatHi;
    end else if (acc_q < SatLo) begin
      sat = SatLo;
    end
  end

  assign sum_o  = sat[SumW-1:0];
  assign busy_o = prod_vld_q;

endmodule

/* rtl/dense_times_packed_lower_triangular_core.sv */
// channel | dir | beat contents                                   | accepted when
// in_i    | in  | mode, row_index, col_index, element_value       | valid && ready
// out_o   | out | product_value, out_row, out_col, out_of_range   | valid && ready
// cfg     | in  | cfg_data_i (matrix_size)                        | cfg_we_i
//
// loads are written into their store as they are taken; an in-range query walks k = col .. n-1
// (n = min(matrix_size, MAX_DIM)), one term per cycle through the shared multiply-accumulate
// unit, behind the registered store reads, then drains; an out-of-range query goes straight
// to the done state, whose result is registered once the output register is free.
// reset clears control and sets matrix_size to 16; stores hold garbage until loaded.
// input beats are taken while a result waits; a finished query holds until that one goes.
module dense_times_packed_lower_triangular_core
  import dtlt_pkg::*;
#(
  parameter int MAX_DIM = DimDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_data_i,
  dtlt_in_if.sink          in_i,
  dtlt_out_if.source       out_o
);

  localparam int DenseDepth = MAX_DIM * MAX_DIM;
  localparam int TriDepth   = (MAX_DIM * (MAX_DIM + 1)) / 2;
  localparam int DaW        = $clog2(DenseDepth);
  localparam int TaW        = $clog2(TriDepth);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [SizeW-1:0] size_q;
  logic [SizeW-1:0] n_eff;
  logic             in_range;
  logic             in_fire;
  logic             out_fire;
  logic             is_query;

  idx_t             r_q, c_q;
  logic             oor_q;
  logic [SizeW-1:0] k_q;
  logic [TaW-1:0]   col_base_q;
  logic             rd_vld_q;
  logic             issue;
  logic             last_k;

  logic             dense_we, tri_we;
  logic [DaW-1:0]   dense_waddr, dense_raddr;
  logic [TaW-1:0]   tri_waddr, tri_raddr;
  val_t             dense_rdata, tri_rdata;
  logic [ValW-1:0]  dense_rraw, tri_rraw;

  logic             mac_clr;
  logic             mac_busy;
  sum_t             mac_sum;

  logic             out_valid_q;
  sum_t             out_value_q;
  idx_t             out_row_q, out_col_q;
  logic             out_oor_q;

  // matrix size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_we_i) begin
      size_q <= cfg_data_i;
    end
  end

  // effective size and range check of the incoming beat
  always_comb begin
    n_eff = size_q;
    if (int'(size_q) > MAX_DIM) begin
      n_eff = SizeW'(MAX_DIM);
    end
  end

  assign in_range = (SizeW'(in_i.row_index) < n_eff) && (SizeW'(in_i.col_index) < n_eff);
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire  = in_i.valid && in_i.ready;
  assign is_query = (in_i.mode == MODE_QUERY);
  assign out_fire = out_valid_q && out_o.ready;

  // store writes from load beats
  assign dense_we = in_fire && (in_i.mode == MODE_LOAD_DENSE) && in_range;
  assign tri_we   = in_fire && (in_i.mode == MODE_LOAD_TRI) && in_range
                    && (in_i.row_index >= in_i.col_index);
  assign dense_waddr = DaW'(int'(in_i.row_index) * MAX_DIM + int'(in_i.col_index));
  assign tri_waddr   = TaW'(int'(in_i.col_index) * MAX_DIM
                            - ((int'(in_i.col_index) * (int'(in_i.col_index) + 1)) >> 1)
                            + int'(in_i.row_index));

  // read addresses walk k along the row of D and the column of T
  assign dense_raddr = DaW'(int'(r_q) * MAX_DIM + int'(k_q));
  assign tri_raddr   = TaW'(int'(col_base_q) + int'(k_q));
  assign issue       = (state_q == ST_RUN);
  assign last_k      = ((SizeW+1)'(k_q) + (SizeW+1)'(1)) >= (SizeW+1)'(n_eff);

  dtlt_ram #(.Width(ValW), .Depth(DenseDepth)) u_dense_ram (
    .clk_i   (clk_i),
    .we_i    (dense_we),
    .waddr_i (dense_waddr),
    .wdata_i (in_i.element_value),
    .raddr_i (dense_raddr),
    .rdata_o (dense_rraw)
  );

  dtlt_ram #(.Width(ValW), .Depth(TriDepth)) u_tri_ram (
    .clk_i   (clk_i),
    .we_i    (tri_we),
    .waddr_i (tri_waddr),
    .wdata_i (in_i.element_value),
    .raddr_i (tri_raddr),
    .rdata_o (tri_rraw)
  );

  assign dense_rdata = val_t'(dense_rraw);
  assign tri_rdata   = val_t'(tri_rraw);

  assign mac_clr = in_fire && is_query;

  dtlt_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (mac_clr),
    .vld_i  (rd_vld_q),
    .a_i    (dense_rdata),
    .b_i    (tri_rdata),
    .busy_o (mac_busy),
    .sum_o  (mac_sum)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && is_query) begin
          state_d = in_range ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (last_k) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !mac_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (in_fire && is_query) begin
        k_q <= SizeW'(in_i.col_index);
      end else if (issue) begin
        k_q <= k_q + SizeW'(1);
      end
    end
  end

  // query context
  always_ff @(posedge clk_i) begin
    if (in_fire && is_query) begin
      r_q        <= in_i.row_index;
      c_q        <= in_i.col_index;
      oor_q      <= !in_range;
      col_base_q <= TaW'(int'(in_i.col_index) * MAX_DIM
                         - ((int'(in_i.col_index) * (int'(in_i.col_index) + 1)) >> 1));
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && (!out_valid_q || out_o.ready)) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!out_valid_q || out_o.ready)) begin
      out_value_q <= oor_q ? '0 : mac_sum;
      out_row_q   <= r_q;
      out_col_q   <= c_q;
      out_oor_q   <= oor_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.product_value = out_value_q;
  assign out_o.out_row       = out_row_q;
  assign out_o.out_col       = out_col_q;
  assign out_o.out_of_range  = out_oor_q;

  // checks
  a_ready_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!rd_vld_q && !mac_busy))
    else $error("input ready while the multiply pipeline is busy");

  a_k_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (k_q < n_eff))
    else $error("term index past the matrix size");

  a_done_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && state_d == ST_DONE) |=> (!mac_busy && !rd_vld_q))
    else $error("result taken before the accumulator settled");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dense_we || tri_we) |-> (state_q == ST_IDLE))
    else $error("store written during a query");

endmodule
